[sv/fths_pkg.sv]
package fths_pkg;

	typedef enum logic [1:0] {
		RM_NEAREST_EVEN = 2'd0,
		RM_TOWARD_ZERO  = 2'd1,
		RM_TOWARD_POS   = 2'd2,
		RM_TOWARD_NEG   = 2'd3
	} round_mode_t;

	// Byte address of the rounding mode register on the APB port.
	localparam logic [1:0]  REG_ROUND_MODE = 2'd0;
	localparam logic [30:0] HALF_MAX_MAG_BITS = 31'h477FE000;
	localparam logic [30:0] SINGLE_INF_MAG = 31'h7F800000;
	localparam logic [14:0] HALF_MAX_CODE = 15'h7BFF;

	typedef struct packed {
		logic [31:0] single_bits;
		logic        last_of_array;
	} in_item_t;

	typedef struct packed {
		logic [15:0] half_bits;
		logic        clamped;
		logic        array_clamped;
		logic        end_of_array;
	} out_item_t;

endpackage

[sv/fths_convert.sv]
module fths_convert (
	input  logic [31:0]              single_bits,
	input  fths_pkg::round_mode_t    round_mode,
	output logic [15:0]              half_bits,
	output logic                     clamped
);

	logic        s;
	logic [7:0]  e;
	logic [22:0] m;
	logic [30:0] mag_in;
	logic        is_nan;
	logic [23:0] sig;
	logic [7:0]  shift;
	logic [23:0] q;
	logic        guard;
	logic        sticky;
	logic [23:0] low_mask;
	logic [14:0] mag;
	logic        inc;
	logic [14:0] rounded;

	always_comb begin
		s = single_bits[31];
		e = single_bits[30:23];
		m = single_bits[22:0];
		mag_in = single_bits[30:0];
		is_nan = mag_in > fths_pkg::SINGLE_INF_MAG;
		clamped = !is_nan && (mag_in > fths_pkg::HALF_MAX_MAG_BITS);
		sig = (e != 8'd0) ? {1'b1, m} : {1'b0, m};
		shift = (e < 8'd113) ? (8'd126 - e) : 8'd13;
		q = '0;
		guard = 1'b0;
		sticky = 1'b0;
		low_mask = '0;
		if (shift > 8'd24) begin
			sticky = sig != 24'd0;
		end else begin
			q = sig >> shift;
			guard = sig[5'(shift - 8'd1)];
			low_mask = (24'd1 << (shift - 8'd1)) - 24'd1;
			sticky = (sig & low_mask) != 24'd0;
		end
		// normal range: exponent rebias plus mantissa without hidden bit
		if (e >= 8'd113)
			mag = {5'(e - 8'd112), 10'd0} + {5'd0, q[9:0]};
		else
			mag = q[14:0];
		case (round_mode)
			fths_pkg::RM_NEAREST_EVEN: inc = guard & (sticky | mag[0]);
			fths_pkg::RM_TOWARD_ZERO:  inc = 1'b0;
			fths_pkg::RM_TOWARD_POS:   inc = (guard | sticky) & ~s;
			default:                   inc = (guard | sticky) & s;
		endcase
		rounded = mag + 15'(inc);
		if (e == 8'hFF && !clamped)
			half_bits = {s, 5'h1F, 1'b1, m[21:13]};
		else if (clamped)
			half_bits = {s, fths_pkg::HALF_MAX_CODE};
		else
			half_bits = {s, rounded};
	end

endmodule

[sv/float_to_half_saturating.sv]
// Each input transfer is captured in the input register and converted combinationally;
// the result is captured in the output register when that stage next advances.
// Throughput: one transfer per cycle while m_axis_tready is high; the input register and
// the result register each advance whenever the stage after them is free or drains in the same cycle.
// Reset (arst_n low, asynchronous): valid flags, sticky clamp bit and round_mode clear.
module float_to_half_saturating (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [31:0] single_bits
	input  logic        s_axis_tlast,   // last_of_array
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [15:0] half_bits
	output logic [1:0]  m_axis_tuser,   // [0] clamped, [1] array_clamped
	output logic        m_axis_tlast    // end_of_array
);

	fths_pkg::round_mode_t round_mode_q;
	fths_pkg::in_item_t    in_s1;
	fths_pkg::out_item_t   out_s2;
	logic                  valid_s1, valid_s2;
	logic                  sticky_q;
	logic                  adv_s1, adv_s2;
	logic [15:0]           half_bits;
	logic                  clamped;

	assign pready = 1'b1;
	assign prdata = (paddr == fths_pkg::REG_ROUND_MODE) ? {30'd0, round_mode_q} : 32'd0;

	// Write the rounding mode on the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			round_mode_q <= fths_pkg::RM_NEAREST_EVEN;
		end else if (psel && penable && pwrite && pready
				&& paddr == fths_pkg::REG_ROUND_MODE) begin
			round_mode_q <= fths_pkg::round_mode_t'(pwdata[1:0]);
		end
	end

	// Advance the output stage when empty or drained; the input stage follows.
	assign adv_s2 = !valid_s2 || m_axis_tready;
	assign adv_s1 = !valid_s1 || adv_s2;
	assign s_axis_tready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && s_axis_tvalid) begin
			in_s1.single_bits   <= s_axis_tdata;
			in_s1.last_of_array <= s_axis_tlast;
		end
	end

	fths_convert u_convert (
		.single_bits (in_s1.single_bits),
		.round_mode  (round_mode_q),
		.half_bits   (half_bits),
		.clamped     (clamped)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			sticky_q <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
			// Gather clamps until the array closes, then drop the sticky bit.
			if (valid_s1)
				sticky_q <= in_s1.last_of_array ? 1'b0 : (sticky_q | clamped);
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			out_s2.half_bits     <= half_bits;
			out_s2.clamped       <= clamped;
			out_s2.array_clamped <= in_s1.last_of_array & (sticky_q | clamped);
			out_s2.end_of_array  <= in_s1.last_of_array;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = out_s2.half_bits;
	assign m_axis_tuser  = {out_s2.array_clamped, out_s2.clamped};
	assign m_axis_tlast  = out_s2.end_of_array;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !m_axis_tready |=> valid_s2 && $stable(out_s2))
		else $error("result changed while stalled");
	a_arr_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && out_s2.array_clamped |-> out_s2.end_of_array)
		else $error("array flag off last item");
	a_sticky_clr: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s2 && valid_s1 && in_s1.last_of_array |=> !sticky_q)
		else $error("sticky not cleared at array end");
	a_clamp_code: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && out_s2.clamped |-> out_s2.half_bits[14:0] == fths_pkg::HALF_MAX_CODE)
		else $error("clamp code wrong");

endmodule

[verif/tb_float_to_half_saturating.sv]
module tb_float_to_half_saturating;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 60;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [1:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;   // [31:0] single_bits
	logic        s_axis_tlast = 1'b0; // last_of_array
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;        // [15:0] half_bits
	logic [1:0]  m_axis_tuser;        // [0] clamped, [1] array_clamped
	logic        m_axis_tlast;        // end_of_array

	float_to_half_saturating u_dut (.*);

	always #5 clk = ~clk;

	// Predictor state: mirrors the rounding register and the sticky clamp bit.
	fths_pkg::round_mode_t rmode = fths_pkg::RM_NEAREST_EVEN;
	logic        clamp_seen = 1'b0;

	fths_pkg::in_item_t  pending_words[$];
	fths_pkg::out_item_t expected_halves[$];
	int          failures = 0;
	int          cycles = 0;
	bit          hold_req = 1'b0;
	bit          hold_done = 1'b0;
	int          hold_left = 0;

	// Round a binary32 word to binary16 in the given mode, no clamping here.
	function automatic logic [15:0] round_to_half(logic [31:0] x, fths_pkg::round_mode_t m);
		logic        s;
		logic [7:0]  e;
		logic [23:0] sig;
		int          sh;
		logic [31:0] q, mag;
		logic        g, st, inc;
		s = x[31];
		e = x[30:23];
		if (e == 8'hFF)
			return {s, 5'h1F, 1'b1, x[21:13]};
		sig = (e != 8'd0) ? {1'b1, x[22:0]} : {1'b0, x[22:0]};
		sh = (e < 8'd113) ? 126 - int'(e) : 13;
		if (sh > 24) begin
			q = '0;
			g = 1'b0;
			st = (sig != 24'd0);
		end else begin
			q = 32'(sig >> sh);
			g = sig[sh-1];
			st = ((32'(sig) & ((32'd1 << (sh - 1)) - 32'd1)) != 32'd0);
		end
		mag = (e >= 8'd113) ? (((32'(e) - 32'd112) << 10) + (q - 32'd1024)) : q;
		case (m)
			fths_pkg::RM_NEAREST_EVEN: inc = g & (st | mag[0]);
			fths_pkg::RM_TOWARD_ZERO:  inc = 1'b0;
			fths_pkg::RM_TOWARD_POS:   inc = (g | st) & ~s;
			default:                   inc = (g | st) & s;
		endcase
		mag = mag + 32'(inc);
		return {s, mag[14:0]};
	endfunction

	// Predict one transfer's result and advance the sticky bit.
	function automatic fths_pkg::out_item_t convert_word(fths_pkg::in_item_t it);
		fths_pkg::out_item_t r;
		logic [30:0] mag;
		logic        nan, clamp;
		mag = it.single_bits[30:0];
		nan = mag > fths_pkg::SINGLE_INF_MAG;
		clamp = !nan && (mag > fths_pkg::HALF_MAX_MAG_BITS);
		r.half_bits = clamp ? {it.single_bits[31], fths_pkg::HALF_MAX_CODE}
			: round_to_half(it.single_bits, rmode);
		r.clamped = clamp;
		clamp_seen = clamp_seen | clamp;
		r.array_clamped = 1'b0;
		if (it.last_of_array) begin
			r.array_clamped = clamp_seen;
			clamp_seen = 1'b0;
		end
		r.end_of_array = it.last_of_array;
		return r;
	endfunction

	task automatic queue_word(logic [31:0] w, logic last);
		fths_pkg::in_item_t it;
		it.single_bits = w;
		it.last_of_array = last;
		pending_words.push_back(it);
		expected_halves.push_back(convert_word(it));
	endtask

	task automatic write_round_mode(logic [31:0] v);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= fths_pkg::REG_ROUND_MODE;
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		rmode = fths_pkg::round_mode_t'(v[1:0]);
	endtask

	// Random word biased toward the interesting half-precision exponent band.
	function automatic logic [31:0] pick_word();
		logic [31:0] w;
		w = $urandom;
		case ($urandom_range(0, 5))
			0, 1: w[30:23] = 8'($urandom_range(100, 143));
			2:    w[30:23] = 8'($urandom_range(140, 143));
			3:    w[30:23] = 8'($urandom_range(0, 112));
			4:    w[30:23] = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
			default: ;
		endcase
		return w;
	endfunction

	// Wait until every expected result has come back, then let the pipe drain.
	task automatic drain();
		while (pending_words.size() != 0 || expected_halves.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Driver: send in bursts with random gaps; hold tvalid across a stall.
	int gap = 0;
	always @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready)
			void'(pending_words.pop_front());
		if (gap > 0) begin
			gap <= gap - 1;
			if (!(s_axis_tvalid && !s_axis_tready))
				s_axis_tvalid <= 1'b0;
		end else if (s_axis_tvalid && !s_axis_tready) begin
			// hold the current transfer
		end else begin
			if (pending_words.size() != 0) begin
				fths_pkg::in_item_t nx;
				nx = pending_words[0];
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= nx.single_bits;
				s_axis_tlast <= nx.last_of_array;
				if ($urandom_range(0, 9) == 0)
					gap <= int'($urandom_range(1, 6));
			end else
				s_axis_tvalid <= 1'b0;
		end
	end

	// Receiver: own stall pattern, plus one long hold-off counted here.
	always @(posedge clk) begin
		if (hold_req && !hold_done) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left > 0)
			hold_left <= hold_left - 1;
		m_axis_tready <= !(hold_req && !hold_done) && (hold_left <= 1)
			&& ($urandom_range(0, 3) != 0 || cycles[8]);
	end

	// Monitor: compare each result transfer with the oldest prediction.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (m_axis_tvalid && m_axis_tready) begin
			if (expected_halves.size() == 0) begin
				failures <= failures + 1;
				$display("%0t unexpected result half=%h", $time, m_axis_tdata);
			end else begin
				fths_pkg::out_item_t ex;
				ex = expected_halves.pop_front();
				if (m_axis_tdata !== ex.half_bits || m_axis_tuser[0] !== ex.clamped
						|| m_axis_tuser[1] !== ex.array_clamped
						|| m_axis_tlast !== ex.end_of_array) begin
					failures <= failures + 1;
					$display("%0t mismatch exp=%h/%b/%b/%b got=%h/%b/%b/%b", $time,
						ex.half_bits, ex.clamped, ex.array_clamped, ex.end_of_array,
						m_axis_tdata, m_axis_tuser[0], m_axis_tuser[1], m_axis_tlast);
				end
			end
		end
		if (cycles >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		logic [31:0] corner[$];
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: zeros, extremes, clamp boundary, infinities, NaNs, tiny values.
		corner = '{32'h0000_0000, 32'h8000_0000, 32'h477F_E000, 32'h477F_E001,
			32'hC77F_E001, 32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0001,
			32'hFFFF_FFFF, 32'h7F80_0001, 32'h3380_0000, 32'h3300_0001,
			32'hB300_0000, 32'h0000_0001, 32'h3880_0000, 32'h387F_FFFF,
			32'h3F80_1000, 32'h3F80_3000, 32'h477F_F000, 32'hC77F_EFFF,
			32'h7F7F_FFFF};
		foreach (corner[i])
			queue_word(corner[i], (i % 4) == 3);
		queue_word(32'h3F80_0000, 1'b1);
		drain();

		// Walk all rounding modes, extremes included; upper bits must be ignored.
		for (int ph = 0; ph < 5; ph++) begin
			write_round_mode((ph == 4) ? 32'hFFFF_FFFC : {$urandom} & ~32'h3 | 32'(ph));
			if (ph == 1) begin
				// Long receiver hold-off while the sender keeps offering.
				hold_req = 1'b1;
				for (int k = 0; k < 40; k++)
					queue_word(pick_word(), $urandom_range(0, 7) == 0);
			end
			for (int k = 0; k < 270; k++)
				queue_word(pick_word(), $urandom_range(0, 7) == 0);
			queue_word(pick_word(), 1'b1);
			drain();
		end

		if (failures == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule

[sim.f]
sv/fths_pkg.sv
sv/fths_convert.sv
sv/float_to_half_saturating.sv
verif/tb_float_to_half_saturating.sv
